@@ design/aar_pkg.sv @@
// Shared types, constants and the CORDIC arctangent table for the rotation-matrix pipeline.
package aar_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int ATAN_ENTRIES          = 24;

    localparam int TURN_LSB        = 23040;
    localparam int QUARTER_LSB     = 5760;
    localparam int RAD_PER_LSB_Q36 = 18740330;

    localparam int XY_W = 34;   // CORDIC x/y, Q30
    localparam int Z_W  = 33;   // CORDIC residual angle, Q30

    localparam logic signed [XY_W-1:0] GAIN_Q30 = XY_W'(652032874);

    typedef logic [1:0] quad_t;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } axis_t;

    // Arctangent of 2^-i in Q30.
    function automatic logic [31:0] cordic_atan(input int idx);
        logic [31:0] t;
        case (idx)
            0:       t = 32'h3243F6A8;
            1:       t = 32'h1DAC6705;
            2:       t = 32'h0FADBAFC;
            3:       t = 32'h07F56EA6;
            4:       t = 32'h03FEAB76;
            5:       t = 32'h01FFD55B;
            6:       t = 32'h00FFFAAA;
            7:       t = 32'h007FFF55;
            8:       t = 32'h003FFFEA;
            9:       t = 32'h001FFFFD;
            10:      t = 32'h000FFFFF;
            11:      t = 32'h0007FFFF;
            12:      t = 32'h0003FFFF;
            13:      t = 32'h0001FFFF;
            14:      t = 32'h0000FFFF;
            15:      t = 32'h00007FFF;
            16:      t = 32'h00003FFF;
            17:      t = 32'h00001FFF;
            18:      t = 32'h00000FFF;
            19:      t = 32'h000007FF;
            20:      t = 32'h000003FF;
            21:      t = 32'h000001FF;
            22:      t = 32'h000000FF;
            default: t = 32'h0000007F;
        endcase
        return t;
    endfunction

endpackage

@@ design/aar_angle.sv @@
// Angle front end: reduction to one turn, quadrant split and conversion to radians.
module aar_angle (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [15:0]            in_angle,
    input  aar_pkg::axis_t                in_axis,
    output logic                          out_valid,
    output logic signed [aar_pkg::Z_W-1:0] out_theta,
    output aar_pkg::quad_t                out_quad,
    output aar_pkg::axis_t                out_axis
);
    import aar_pkg::*;

    localparam logic [16:0] OFFSET = 17'(2 * TURN_LSB);
    localparam logic [16:0] T1     = 17'(TURN_LSB);
    localparam logic [16:0] T2     = 17'(2 * TURN_LSB);
    localparam logic [16:0] T3     = 17'(3 * TURN_LSB);
    localparam logic [14:0] Q1     = 15'(QUARTER_LSB);
    localparam logic [14:0] Q2     = 15'(2 * QUARTER_LSB);
    localparam logic [14:0] Q3     = 15'(3 * QUARTER_LSB);

    logic [2:0]  v_reg;
    logic [14:0] m_reg, m_next;
    axis_t       ax1_reg, ax2_reg, ax3_reg;
    quad_t       quad2_reg, quad2_next, quad3_reg;
    logic [12:0] r_reg, r_next;
    logic signed [Z_W-1:0] theta_reg, theta_next;
    logic [16:0] t_sum;
    logic [37:0] prod;

    // The biased angle is always positive; at most three turns come off.
    always_comb begin
        t_sum = 17'(signed'({in_angle[15], in_angle})) + OFFSET;
        if (t_sum >= T3)      m_next = 15'(t_sum - T3);
        else if (t_sum >= T2) m_next = 15'(t_sum - T2);
        else if (t_sum >= T1) m_next = 15'(t_sum - T1);
        else                  m_next = 15'(t_sum);
    end

    always_comb begin
        if (m_reg >= Q3) begin
            quad2_next = 2'd3;
            r_next     = 13'(m_reg - Q3);
        end else if (m_reg >= Q2) begin
            quad2_next = 2'd2;
            r_next     = 13'(m_reg - Q2);
        end else if (m_reg >= Q1) begin
            quad2_next = 2'd1;
            r_next     = 13'(m_reg - Q1);
        end else begin
            quad2_next = 2'd0;
            r_next     = m_reg[12:0];
        end
    end

    always_comb begin
        prod       = 38'(r_reg) * 38'(RAD_PER_LSB_Q36) + 38'd32;
        theta_next = Z_W'(prod[37:6]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg     <= m_next;
            ax1_reg   <= in_axis;
            quad2_reg <= quad2_next;
            r_reg     <= r_next;
            ax2_reg   <= ax1_reg;
            theta_reg <= theta_next;
            quad3_reg <= quad2_reg;
            ax3_reg   <= ax2_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign out_theta = theta_reg;
    assign out_quad  = quad3_reg;
    assign out_axis  = ax3_reg;
endmodule

@@ design/aar_cordic_stage.sv @@
// One registered CORDIC rotation in rotation mode.
module aar_cordic_stage #(
    parameter int IDX = 0
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [aar_pkg::XY_W-1:0] in_x,
    input  logic signed [aar_pkg::XY_W-1:0] in_y,
    input  logic signed [aar_pkg::Z_W-1:0]  in_z,
    input  aar_pkg::quad_t                  in_quad,
    input  aar_pkg::axis_t                  in_axis,
    output logic                            out_valid,
    output logic signed [aar_pkg::XY_W-1:0] out_x,
    output logic signed [aar_pkg::XY_W-1:0] out_y,
    output logic signed [aar_pkg::Z_W-1:0]  out_z,
    output aar_pkg::quad_t                  out_quad,
    output aar_pkg::axis_t                  out_axis
);
    import aar_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = Z_W'(cordic_atan(IDX));

    logic                   v_reg;
    logic signed [XY_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    quad_t                  quad_reg;
    axis_t                  axis_reg;

    always_comb begin
        if (!in_z[Z_W-1]) begin
            x_next = in_x - (in_y >>> IDX);
            y_next = in_y + (in_x >>> IDX);
            z_next = in_z - ATAN;
        end else begin
            x_next = in_x + (in_y >>> IDX);
            y_next = in_y - (in_x >>> IDX);
            z_next = in_z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            quad_reg <= in_quad;
            axis_reg <= in_axis;
        end
    end

    assign out_valid = v_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_quad  = quad_reg;
    assign out_axis  = axis_reg;
endmodule

@@ design/aar_matrix.sv @@
// Quadrant mapping and the three-stage Rodrigues matrix multiply, round and saturate.
module aar_matrix (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [aar_pkg::XY_W-1:0] in_c,
    input  logic signed [aar_pkg::XY_W-1:0] in_s,
    input  aar_pkg::quad_t                  in_quad,
    input  aar_pkg::axis_t                  in_axis,
    output logic                            out_valid,
    output logic [143:0]                    out_data
);
    import aar_pkg::*;

    localparam int PW = 68;

    function automatic logic [15:0] to_q14(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] r;
        logic signed [PW-45:0] q;
        r = v + (PW'(1) <<< 43);
        q = r[PW-1:44];
        if (q > (PW-44)'(32767))       return 16'h7FFF;
        else if (q < -(PW-44)'(32768)) return 16'h8000;
        else                           return q[15:0];
    endfunction

    logic [2:0] v_reg;

    // Stage one.
    logic signed [XY_W-1:0] c_m, s_m;
    logic signed [32:0] xx_reg, yy_reg, zz_reg, oxx_reg, oyy_reg, ozz_reg;
    logic signed [32:0] xy_reg, yz_reg, zx_reg;
    logic signed [XY_W-1:0] c_reg;
    logic signed [XY_W:0]   omc_reg;
    logic signed [49:0] xs_reg, ys_reg, zs_reg;
    logic signed [32:0] xx_n, yy_n, zz_n;

    // Stage two.
    logic signed [PW-1:0] dx_reg, dy_reg, dz_reg, pxy_reg, pyz_reg, pzx_reg;
    logic signed [PW-1:0] bx_reg, by_reg, bz_reg, sx_reg, sy_reg, sz_reg;

    logic [143:0] data_reg, data_next;

    always_comb begin
        case (in_quad)
            2'd0:    begin c_m = in_c;  s_m = in_s;  end
            2'd1:    begin c_m = -in_s; s_m = in_c;  end
            2'd2:    begin c_m = -in_c; s_m = -in_s; end
            default: begin c_m = in_s;  s_m = -in_c; end
        endcase
        xx_n = 33'(in_axis.x) * 33'(in_axis.x);
        yy_n = 33'(in_axis.y) * 33'(in_axis.y);
        zz_n = 33'(in_axis.z) * 33'(in_axis.z);
    end

    always_comb begin
        data_next[15:0]    = to_q14(bx_reg + dx_reg);
        data_next[31:16]   = to_q14(pxy_reg - sz_reg);
        data_next[47:32]   = to_q14(pzx_reg + sy_reg);
        data_next[63:48]   = to_q14(pxy_reg + sz_reg);
        data_next[79:64]   = to_q14(by_reg + dy_reg);
        data_next[95:80]   = to_q14(pyz_reg - sx_reg);
        data_next[111:96]  = to_q14(pzx_reg - sy_reg);
        data_next[127:112] = to_q14(pyz_reg + sx_reg);
        data_next[143:128] = to_q14(bz_reg + dz_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg  <= xx_n;
            yy_reg  <= yy_n;
            zz_reg  <= zz_n;
            oxx_reg <= (33'sd1 <<< 28) - xx_n;
            oyy_reg <= (33'sd1 <<< 28) - yy_n;
            ozz_reg <= (33'sd1 <<< 28) - zz_n;
            xy_reg  <= 33'(in_axis.x) * 33'(in_axis.y);
            yz_reg  <= 33'(in_axis.y) * 33'(in_axis.z);
            zx_reg  <= 33'(in_axis.z) * 33'(in_axis.x);
            c_reg   <= c_m;
            omc_reg <= ((XY_W+1)'(1) <<< 30) - (XY_W+1)'(c_m);
            xs_reg  <= 50'(in_axis.x) * 50'(s_m);
            ys_reg  <= 50'(in_axis.y) * 50'(s_m);
            zs_reg  <= 50'(in_axis.z) * 50'(s_m);

            bx_reg  <= PW'(xx_reg) <<< 30;
            by_reg  <= PW'(yy_reg) <<< 30;
            bz_reg  <= PW'(zz_reg) <<< 30;
            dx_reg  <= PW'(oxx_reg) * PW'(c_reg);
            dy_reg  <= PW'(oyy_reg) * PW'(c_reg);
            dz_reg  <= PW'(ozz_reg) * PW'(c_reg);
            pxy_reg <= PW'(xy_reg) * PW'(omc_reg);
            pyz_reg <= PW'(yz_reg) * PW'(omc_reg);
            pzx_reg <= PW'(zx_reg) * PW'(omc_reg);
            sx_reg  <= PW'(xs_reg) <<< 14;
            sy_reg  <= PW'(ys_reg) <<< 14;
            sz_reg  <= PW'(zs_reg) <<< 14;

            data_reg <= data_next;
        end
    end

    assign out_valid = v_reg[2];
    assign out_data  = data_reg;
endmodule

@@ design/axis_angle_rotation_matrix.sv @@
// One word per cycle is accepted while the output is not stalled; the whole
// pipeline advances together, so one stage per CORDIC rotation plus three angle
// and three matrix stages set the depth.
// Reset (aresetn low, synchronous) clears every stage valid bit; data registers
// are not reset and no clearing time is needed after reset.
module axis_angle_rotation_matrix #(
    parameter int CORDIC_ITERATIONS = aar_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // Fields from bit 0: axis_x, axis_y, axis_z, angle_deg (16 bits each).
    input  logic [63:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // Fields from bit 0: r00, r01, r02, r10, r11, r12, r20, r21, r22 (16 bits each).
    output logic [143:0] m_axis_tdata
);
    import aar_pkg::*;

    // The model caps the rotation count at the size of the arctangent table.
    localparam int N = (CORDIC_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_ITERATIONS;

    // The pipeline moves whenever the output register is empty or being drained.
    // A stall freezes every stage, so nothing is lost or repeated.
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    axis_t in_axis;
    assign in_axis.x = s_axis_tdata[15:0];
    assign in_axis.y = s_axis_tdata[31:16];
    assign in_axis.z = s_axis_tdata[47:32];

    logic                   v_c   [N+1];
    logic signed [XY_W-1:0] x_c   [N+1];
    logic signed [XY_W-1:0] y_c   [N+1];
    logic signed [Z_W-1:0]  z_c   [N+1];
    quad_t                  quad_c[N+1];
    axis_t                  axis_c[N+1];

    aar_angle u_angle (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_angle  (s_axis_tdata[63:48]),
        .in_axis   (in_axis),
        .out_valid (v_c[0]),
        .out_theta (z_c[0]),
        .out_quad  (quad_c[0]),
        .out_axis  (axis_c[0])
    );

    // The rotation starts from the reciprocal of the limiting gain so the result needs no scaling.
    assign x_c[0] = GAIN_Q30;
    assign y_c[0] = '0;

    for (genvar i = 0; i < N; i++) begin : g_cordic
        aar_cordic_stage #(.IDX(i)) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v_c[i]),
            .in_x      (x_c[i]),
            .in_y      (y_c[i]),
            .in_z      (z_c[i]),
            .in_quad   (quad_c[i]),
            .in_axis   (axis_c[i]),
            .out_valid (v_c[i+1]),
            .out_x     (x_c[i+1]),
            .out_y     (y_c[i+1]),
            .out_z     (z_c[i+1]),
            .out_quad  (quad_c[i+1]),
            .out_axis  (axis_c[i+1])
        );
    end

    // The final residual angle is not needed downstream.
    logic unused_z;
    assign unused_z = ^z_c[N];

    // The last matrix stage is the output register itself.
    aar_matrix u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v_c[N] && !unused_z || v_c[N] && unused_z),
        .in_c      (x_c[N]),
        .in_s      (y_c[N]),
        .in_quad   (quad_c[N]),
        .in_axis   (axis_c[N]),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );
endmodule
